// ===== rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants for the KMP pattern search block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

    localparam int MAX_PATTERN_DEF   = 64;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CFG_W = 7;   // pattern_length register
    localparam int SYM_W = 8;   // pattern / text byte
    localparam int POS_W = 16;  // reported start position

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/kmp_pattern_search.sv =====
// ----------------------------------------------------------------------------
// kmp_pattern_search
// First-occurrence byte pattern search (Knuth-Morris-Pratt) over a stream.
// ----------------------------------------------------------------------------
// Requests on s_axis carry a command in tuser: append a pattern byte, a text
// byte, restart the text scan, or clear the pattern. Each appended byte gets
// its failure link computed on arrival. Text bytes walk the failure links; on
// the first full match one result with found=1 and the start index is sent on
// m_axis and further text is ignored until a restart. A text byte with tlast
// and no match sends found=0, position 0. Restart, clear, a dropped byte,
// ignored text after the scan ended, text before the pattern is complete and
// a first pattern byte are handled in the idle state; other pattern bytes and
// text bytes enter a step state that follows the failure links (one
// synchronous read of the pattern and failure RAMs per cycle). No request is
// taken while a walk or a result is pending. The output register lets the
// result wait on m_axis_tready. The user must write pattern_length on the cfg
// port only while idle; the block itself does not enforce it. Values of 0 act
// as 1, values above MAX_PATTERN as MAX_PATTERN. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_pattern_search #(
    parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // request stream
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire  [7:0]                  s_axis_tdata,   // [7:0] symbol
    input  wire  [1:0]                  s_axis_tuser,   // [1:0] command
    input  wire                         s_axis_tlast,   // last_text
    // result stream
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [15:0]                 m_axis_tdata,   // [15:0] position
    output logic                        m_axis_tuser,   // [0] found
    // pattern_length register
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [kmp_pkg::CFG_W-1:0]   i_cfg_data
);
    import kmp_pkg::*;

    localparam int IW = $clog2(MAX_PATTERN);
    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic [CFG_W-1:0] r_cfg_len;
    logic [CW-1:0]    eff_len;
    logic [31:0]      cfg_ext;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [7:0]    wr_pat;
    logic [CW-1:0] wr_fail;
    logic          rd_en;
    logic [CW-1:0] rd_q;
    logic [7:0]    rd_pat;
    logic [CW-1:0] rd_fail;

    logic    res_valid;
    logic    res_ready;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    // config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_cfg_len <= i_cfg_data;
        end
    end

    // saturate length to 1..MAX_PATTERN
    assign cfg_ext = 32'(r_cfg_len);
    always_comb begin
        if (cfg_ext == 32'd0) begin
            eff_len = CW'(1);
        end else if (cfg_ext > 32'(MAX_PATTERN)) begin
            eff_len = CW'(MAX_PATTERN);
        end else begin
            eff_len = cfg_ext[CW-1:0];
        end
    end

    kmp_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_pat  (wr_pat),
        .i_wr_fail (wr_fail),
        .i_rd_en   (rd_en),
        .i_rd_q    (rd_q),
        .o_rd_pat  (rd_pat),
        .o_rd_fail (rd_fail)
    );

    kmp_engine #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (t_cmd'(s_axis_tuser)),
        .i_sym       (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_len       (eff_len),
        .o_wr_en     (wr_en),
        .o_wr_idx    (wr_idx),
        .o_wr_pat    (wr_pat),
        .o_wr_fail   (wr_fail),
        .o_rd_en     (rd_en),
        .o_rd_q      (rd_q),
        .i_rd_pat    (rd_pat),
        .i_rd_fail   (rd_fail),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register: result waits here for the sink
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.position;
    assign m_axis_tuser  = r_out.found;

endmodule

`default_nettype wire

// ===== rtl/kmp_store.sv =====
// ----------------------------------------------------------------------------
// kmp_store
// Pattern bytes and failure links, two synchronous RAMs sharing one
// write address and one read state (pattern at q, failure link at q-1).
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_store #(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_wr_en,
    input  wire  [$clog2(MAX_PATTERN)-1:0]         i_wr_idx,
    input  wire  [kmp_pkg::SYM_W-1:0]              i_wr_pat,
    input  wire  [$clog2(MAX_PATTERN+1)-1:0]       i_wr_fail,
    input  wire                                    i_rd_en,
    input  wire  [$clog2(MAX_PATTERN+1)-1:0]       i_rd_q,
    output logic [kmp_pkg::SYM_W-1:0]              o_rd_pat,
    output logic [$clog2(MAX_PATTERN+1)-1:0]       o_rd_fail
);
    import kmp_pkg::*;

    localparam int IW = $clog2(MAX_PATTERN);
    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic [SYM_W-1:0] r_pat_mem  [MAX_PATTERN];
    logic [CW-1:0]    r_fail_mem [MAX_PATTERN];

    logic [CW-1:0] qm1;
    logic [IW-1:0] pat_addr;
    logic [IW-1:0] fail_addr;

    assign qm1       = i_rd_q - CW'(1);
    assign pat_addr  = i_rd_q[IW-1:0];
    assign fail_addr = qm1[IW-1:0];   // don't care when q is zero

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pat_mem[i_wr_idx]  <= i_wr_pat;
            r_fail_mem[i_wr_idx] <= i_wr_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_pat  <= r_pat_mem[pat_addr];
            o_rd_fail <= r_fail_mem[fail_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kmp_engine.sv =====
// ----------------------------------------------------------------------------
// kmp_engine
// Command sequencer: runs the failure-link walk against the store for both
// pattern loading and text scanning, one link per cycle.
// States are held as q = k + 1 so that "minus one" is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_engine #(
    parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // request in
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  kmp_pkg::t_cmd                          i_cmd,
    input  wire  [kmp_pkg::SYM_W-1:0]              i_sym,
    input  wire                                    i_last,
    // effective pattern length, 1..MAX_PATTERN
    input  wire  [$clog2(MAX_PATTERN+1)-1:0]       i_len,
    // store
    output logic                                   o_wr_en,
    output logic [$clog2(MAX_PATTERN)-1:0]         o_wr_idx,
    output logic [kmp_pkg::SYM_W-1:0]              o_wr_pat,
    output logic [$clog2(MAX_PATTERN+1)-1:0]       o_wr_fail,
    output logic                                   o_rd_en,
    output logic [$clog2(MAX_PATTERN+1)-1:0]       o_rd_q,
    input  wire  [kmp_pkg::SYM_W-1:0]              i_rd_pat,
    input  wire  [$clog2(MAX_PATTERN+1)-1:0]       i_rd_fail,
    // result
    output logic                                   o_res_valid,
    input  wire                                    i_res_ready,
    output kmp_pkg::t_result                       o_res
);
    import kmp_pkg::*;

    localparam int IW = $clog2(MAX_PATTERN);
    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int DW = 33;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                   r_state,  n_state;
    logic [CW-1:0]            r_loaded, n_loaded;
    logic [CW-1:0]            r_prefix, n_prefix;
    logic [CW-1:0]            r_match,  n_match;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic                     r_done,   n_done;
    logic                     r_text,   n_text;    // walk is for text, not load
    logic [CW-1:0]            r_q,      n_q;
    logic [SYM_W-1:0]         r_sym,    n_sym;
    logic                     r_last,   n_last;
    logic [POSITION_BITS-1:0] r_cur,    n_cur;     // index of current text byte
    t_result                  r_res,    n_res;

    logic          hit;
    logic [CW-1:0] q_next;
    logic [CW-1:0] q_start;
    logic [DW-1:0] pos_ext;
    logic [DW-1:0] k_ext;
    logic [DW-1:0] diff;

    assign hit     = (i_rd_pat == r_sym);
    // at q zero a mismatch stays at zero; the failure read is not valid there
    assign q_next  = hit ? r_q + CW'(1) : ((r_q == '0) ? '0 : i_rd_fail);
    assign q_start = (r_match >= i_len) ? '0 : r_match;
    assign pos_ext = DW'(r_cur);
    assign k_ext   = DW'(i_len) - DW'(1);
    assign diff    = pos_ext - k_ext;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_EMIT);
    assign o_res       = r_res;

    always_comb begin
        n_state  = r_state;
        n_loaded = r_loaded;
        n_prefix = r_prefix;
        n_match  = r_match;
        n_pos    = r_pos;
        n_done   = r_done;
        n_text   = r_text;
        n_q      = r_q;
        n_sym    = r_sym;
        n_last   = r_last;
        n_cur    = r_cur;
        n_res    = r_res;
        o_wr_en   = 1'b0;
        o_wr_idx  = r_loaded[IW-1:0];
        o_wr_pat  = r_sym;
        o_wr_fail = q_next;
        o_rd_en   = 1'b0;
        o_rd_q    = q_next;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sym  = i_sym;
                    n_last = i_last;
                    case (i_cmd)
                        CMD_APPEND: begin
                            if (r_loaded == CW'(MAX_PATTERN)) begin
                                // store full, drop the byte
                            end else if (r_loaded == '0) begin
                                o_wr_en   = 1'b1;
                                o_wr_pat  = i_sym;
                                o_wr_fail = '0;
                                n_prefix  = '0;
                                n_loaded  = CW'(1);
                            end else begin
                                o_rd_en = 1'b1;
                                o_rd_q  = r_prefix;
                                n_q     = r_prefix;
                                n_text  = 1'b0;
                                n_state = ST_STEP;
                            end
                        end
                        CMD_RESTART: begin
                            n_match = '0;
                            n_pos   = '0;
                            n_done  = 1'b0;
                        end
                        CMD_CLEAR: begin
                            n_loaded = '0;
                            n_prefix = '0;
                            n_match  = '0;
                        end
                        CMD_TEXT: begin
                            if (!r_done) begin
                                n_cur = r_pos;
                                if (r_pos != '1) begin
                                    n_pos = r_pos + POSITION_BITS'(1);
                                end
                                if (r_loaded >= i_len) begin
                                    o_rd_en = 1'b1;
                                    o_rd_q  = q_start;
                                    n_q     = q_start;
                                    n_text  = 1'b1;
                                    n_state = ST_STEP;
                                end else begin
                                    n_match = '0;
                                    if (i_last) begin
                                        n_done  = 1'b1;
                                        n_res   = '{found: 1'b0, position: '0};
                                        n_state = ST_EMIT;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_STEP: begin
                if (hit || r_q == '0) begin
                    if (!r_text) begin
                        o_wr_en  = 1'b1;
                        n_prefix = q_next;
                        n_loaded = r_loaded + CW'(1);
                        n_state  = ST_IDLE;
                    end else begin
                        n_match = q_next;
                        if (q_next == i_len) begin
                            n_done  = 1'b1;
                            n_res   = '{found: 1'b1,
                                        position: (pos_ext >= k_ext) ?
                                                  diff[POS_W-1:0] : '0};
                            n_state = ST_EMIT;
                        end else if (r_last) begin
                            n_done  = 1'b1;
                            n_res   = '{found: 1'b0, position: '0};
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    // mismatch: follow the failure link, read it next
                    o_rd_en = 1'b1;
                    n_q     = q_next;
                end
            end
            ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_loaded <= '0;
            r_prefix <= '0;
            r_match  <= '0;
            r_pos    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_prefix <= n_prefix;
            r_match  <= n_match;
            r_pos    <= n_pos;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_text <= n_text;
        r_q    <= n_q;
        r_sym  <= n_sym;
        r_last <= n_last;
        r_cur  <= n_cur;
        r_res  <= n_res;
    end

    // prefix link always points inside the loaded pattern
    a_prefix_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loaded != '0) |-> (r_prefix < r_loaded))
        else $error("prefix link beyond loaded pattern");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CW'(MAX_PATTERN))
        else $error("loaded count overflow");

    // walk never addresses past the store
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> (r_q < CW'(MAX_PATTERN)))
        else $error("walk state out of store range");

    // a no-match result carries position zero
    a_nomatch_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |-> (o_res.position == '0))
        else $error("no-match result with nonzero position");

    // a result ends the scan
    a_result_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_done)
        else $error("result without scan done");

endmodule

`default_nettype wire
